// ----- src/pebq_pkg.sv -----
// Package for the priority evicting bounded queue: types, codes and shared helpers.
package pebq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 128;
    localparam int PAYLOAD_BITS_DEF = 16;
    localparam logic [7:0] FILL_LIMIT_RESET = 8'd100;
    localparam logic [1:0] SEV_CRITICAL = 2'd2;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STATUS_PUSHED  = 3'd0,
        STATUS_EVICTED = 3'd1,
        STATUS_DROPPED = 3'd2,
        STATUS_POPPED  = 3'd3,
        STATUS_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_POP_WAIT,
        CS_SCAN,
        CS_SHIFT,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        op_t         operation;
        logic [1:0]  severity;
        logic [15:0] payload;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  item_severity;
        logic [15:0] item_payload;
        logic [7:0]  fill_level;
        logic [31:0] drop_total;
        logic [31:0] evict_total;
    } out_item_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ----- src/pebq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pebq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/pebq_ctrl.sv -----
// Queue sequencer: circular buffer in RAM, eviction scan and close-up, counters.
module pebq_ctrl #(
    parameter int QUEUE_DEPTH  = pebq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = pebq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          fill_limit,
    input  logic                in_valid,
    output logic                in_ready,
    input  pebq_pkg::in_item_t  in_data,
    output logic                res_valid,
    input  logic                res_ready,
    output pebq_pkg::out_item_t res_data
);
    import pebq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = 2 + PAYLOAD_BITS;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int PCOPY = (PAYLOAD_BITS < 16) ? PAYLOAD_BITS : 16;
    localparam int FCOPY = (CNT_W < 8) ? CNT_W : 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] drop_reg, drop_next;
    logic [31:0] evict_reg, evict_next;
    op_t op_reg, op_next;
    logic [1:0] sev_reg, sev_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    status_t status_reg, status_next;
    logic [1:0] osev_reg, osev_next;
    logic [15:0] opay_reg, opay_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic [IDX_W-1:0] flt_idx_reg, flt_idx_next;
    logic flt_reg, flt_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [PAYLOAD_BITS-1:0] pay_in;
    logic [1:0]              sev_in;
    logic [15:0]             rd_pay16;
    logic [7:0]              fill8;
    logic                    full;
    logic                    hit;

    pebq_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        pay_in   = '0;
        rd_pay16 = '0;
        fill8    = '0;
        for (int b = 0; b < PCOPY; b++) begin
            pay_in[b]   = in_data.payload[b];
            rd_pay16[b] = ram_rdata[b];
        end
        for (int b = 0; b < FCOPY; b++) begin
            fill8[b] = count_reg[b];
        end
    end

    assign sev_in = (in_data.severity > SEV_CRITICAL) ? SEV_CRITICAL : in_data.severity;
    // fill limit of zero acts as one, above the depth as the depth
    assign full = ((count_reg != '0) || (fill_limit != 8'd0)) &&
                  ((CMP_W'(count_reg) >= CMP_W'(fill_limit)) || (count_reg == FULL_CNT));
    assign hit  = flt_reg && (ram_rdata[ENT_W-1 -: 2] < sev_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= '0;
            evict_reg <= '0;
            flt_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            evict_reg <= evict_next;
            flt_reg   <= flt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sev_reg     <= sev_next;
        pay_reg     <= pay_next;
        status_reg  <= status_next;
        osev_reg    <= osev_next;
        opay_reg    <= opay_next;
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        left_reg    <= left_next;
        iss_idx_reg <= iss_idx_next;
        flt_idx_reg <= flt_idx_next;
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        evict_next   = evict_reg;
        op_next      = op_reg;
        sev_next     = sev_reg;
        pay_next     = pay_reg;
        status_next  = status_reg;
        osev_next    = osev_reg;
        opay_next    = opay_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        left_next    = left_reg;
        iss_idx_next = iss_idx_reg;
        flt_idx_next = flt_idx_reg;
        flt_next     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = tail_reg;
        ram_wdata    = {sev_reg, pay_reg};
        ram_raddr    = head_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            CS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_data.operation;
                    sev_next   = sev_in;
                    pay_next   = pay_in;
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH: begin
                osev_next = '0;
                opay_next = '0;
                if (op_reg == OP_POP) begin
                    if (count_reg == '0) begin
                        status_next = STATUS_EMPTY;
                        state_next  = CS_FINISH;
                    end else begin
                        ram_raddr  = head_reg;
                        state_next = CS_POP_WAIT;
                    end
                end else if (!full) begin
                    ram_we      = 1'b1;
                    ram_waddr   = tail_reg;
                    tail_next   = ptr_inc(tail_reg);
                    count_next  = count_reg + 1'b1;
                    status_next = STATUS_PUSHED;
                    state_next  = CS_FINISH;
                end else begin
                    rd_ptr_next  = head_reg;
                    left_next    = count_reg;
                    iss_idx_next = '0;
                    state_next   = CS_SCAN;
                end
            end
            CS_POP_WAIT: begin
                osev_next   = ram_rdata[ENT_W-1 -: 2];
                opay_next   = rd_pay16;
                head_next   = ptr_inc(head_reg);
                count_next  = count_reg - 1'b1;
                status_next = STATUS_POPPED;
                state_next  = CS_FINISH;
            end
            CS_SCAN: begin
                // oldest entry of lower tier: wr_ptr holds the address in flight
                if (hit) begin
                    evict_next  = sat_inc(evict_reg);
                    rd_ptr_next = ptr_inc(wr_ptr_reg);
                    left_next   = count_reg - CNT_W'(flt_idx_reg) - 1'b1;
                    state_next  = CS_SHIFT;
                end else if (!flt_reg && (left_reg == '0)) begin
                    drop_next   = sat_inc(drop_reg);
                    status_next = STATUS_DROPPED;
                    state_next  = CS_FINISH;
                end else if (left_reg != '0) begin
                    ram_raddr    = rd_ptr_reg;
                    rd_ptr_next  = ptr_inc(rd_ptr_reg);
                    wr_ptr_next  = rd_ptr_reg;
                    left_next    = left_reg - 1'b1;
                    flt_idx_next = iss_idx_reg;
                    iss_idx_next = iss_idx_reg + 1'b1;
                    flt_next     = 1'b1;
                end
            end
            CS_SHIFT: begin
                if (left_reg != '0) begin
                    ram_raddr   = rd_ptr_reg;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    left_next   = left_reg - 1'b1;
                    flt_next    = 1'b1;
                end
                if (flt_reg) begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg;
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                end else if (left_reg == '0) begin
                    // gap closed: new entry lands in the last slot, fill unchanged
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg;
                    ram_wdata   = {sev_reg, pay_reg};
                    status_next = STATUS_EVICTED;
                    state_next  = CS_FINISH;
                end
            end
            CS_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        res_data.status        = status_reg;
        res_data.item_severity = osev_reg;
        res_data.item_payload  = opay_reg;
        res_data.fill_level    = fill8;
        res_data.drop_total    = drop_reg;
        res_data.evict_total   = evict_reg;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above queue depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg == $past(count_reg)) ||
                           (count_reg == $past(count_reg) + 1'b1) ||
                           (count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_IDLE) |-> !ram_we)
        else $error("store written while idle");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == CS_SHIFT) && flt_reg && (left_reg != '0)) |->
        (rd_ptr_reg != wr_ptr_reg))
        else $error("close-up read and write hit the same entry");

endmodule

// ----- src/priority_evicting_bounded_queue_unit.sv -----
// Top level: fill limit register, result output register and queue sequencer.
// Push into a full queue: scan of i+1 entries to the first lower tier, then close-up
// of the n-1-i later entries; with no lower tier all n entries are scanned and the push drops.
// One transaction at a time; the RAM's single read port sets the scan pace.
// Reset clears pointers, fill, counters and sets fill_limit to 100; the store is not cleared.
module priority_evicting_bounded_queue_unit #(
    parameter int QUEUE_DEPTH  = pebq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = pebq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pebq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pebq_pkg::out_item_t m_data,
    input  logic                cfg_wen,
    input  logic [7:0]          cfg_wdata
);
    import pebq_pkg::*;

    logic [7:0] fill_limit_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       res_valid;
    logic       res_ready;
    out_item_t  res_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_limit_reg <= FILL_LIMIT_RESET;
        end else if (cfg_wen) begin
            fill_limit_reg <= cfg_wdata;
        end
    end

    pebq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fill_limit(fill_limit_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the priority evicting bounded queue unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pebq_pkg::*;

    localparam int          DEPTH        = QUEUE_DEPTH_DEF;
    localparam logic [1:0]  SEV_INFO     = 2'd0;
    localparam logic [1:0]  SEV_WARNING  = 2'd1;
    localparam logic [1:0]  SEV_OVERFLOW = 2'd3;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
    localparam int          MAX_PRINTS   = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;

    // Shadow of the alert queue
    logic [1:0]  shadow_sev [DEPTH];
    logic [15:0] shadow_pay [DEPTH];
    int unsigned shadow_count;
    logic [31:0] shadow_drops;
    logic [31:0] shadow_evicts;
    logic [7:0]  shadow_limit;

    out_item_t   pending_results [$];
    out_item_t   expected_now;
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned limit_writes;
    bit          sender_idle;
    bit          receiver_idle;
    int          rx_gap;
    int          drain_wait;

    priority_evicting_bounded_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = 32'(shadow_limit);
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        return lim;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic void shadow_remove(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_sev[i] = shadow_sev[i + 1];
            shadow_pay[i] = shadow_pay[i + 1];
        end
        shadow_count--;
    endfunction

    // Applies one transaction to the shadow queue and returns the result it should give
    function automatic out_item_t alert_queue_step(input in_item_t it);
        out_item_t   res;
        logic [1:0]  sev;
        bit          room;
        bit          found;
        int unsigned i;
        res = '0;
        res.status = STATUS_PUSHED;
        if (it.operation == OP_PUSH) begin
            sev   = (it.severity > SEV_CRITICAL) ? SEV_CRITICAL : it.severity;
            room  = 1'b1;
            if (shadow_count >= active_limit()) begin
                room  = 1'b0;
                found = 1'b0;
                i     = 0;
                while (!found && i < shadow_count && i < DEPTH) begin
                    if (shadow_sev[i] < sev) begin
                        shadow_remove(i);
                        shadow_evicts = bump(shadow_evicts);
                        res.status    = STATUS_EVICTED;
                        room  = 1'b1;
                        found = 1'b1;
                    end
                    i++;
                end
            end
            if (room && shadow_count < DEPTH) begin
                shadow_sev[shadow_count] = sev;
                shadow_pay[shadow_count] = it.payload;
                shadow_count++;
            end else begin
                shadow_drops = bump(shadow_drops);
                res.status   = STATUS_DROPPED;
            end
        end else if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.item_severity = shadow_sev[0];
            res.item_payload  = shadow_pay[0];
            shadow_remove(0);
            res.status = STATUS_POPPED;
        end
        res.fill_level  = shadow_count[7:0];
        res.drop_total  = shadow_drops;
        res.evict_total = shadow_evicts;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, status", 32'(m_data.status), 32'd0);
            end else begin
                expected_now = pending_results[0];
                pending_results.delete(0);
                check_field("status", 32'(m_data.status), 32'(expected_now.status));
                check_field("item_severity", 32'(m_data.item_severity),
                            32'(expected_now.item_severity));
                check_field("item_payload", 32'(m_data.item_payload),
                            32'(expected_now.item_payload));
                check_field("fill_level", 32'(m_data.fill_level),
                            32'(expected_now.fill_level));
                check_field("drop_total", m_data.drop_total, expected_now.drop_total);
                check_field("evict_total", m_data.evict_total, expected_now.evict_total);
            end
            results_seen++;
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            rx_gap = receiver_idle ? pick_gap() : 0;
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                repeat (rx_gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    // s_valid is left high after a transaction; the next call or a pause decides its fate
    task automatic send_item(input in_item_t it);
        int        gap;
        out_item_t want;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = alert_queue_step(it);
        pending_results = {pending_results, want};
        items_sent++;
    endtask

    task automatic push_entry(input logic [1:0] sev, input logic [15:0] pay);
        in_item_t it;
        it.operation = OP_PUSH;
        it.severity  = sev;
        it.payload   = pay;
        send_item(it);
    endtask

    task automatic pop_entry();
        in_item_t it;
        it.operation = OP_POP;
        it.severity  = 2'($urandom_range(0, 3));
        it.payload   = 16'($urandom_range(0, 65535));
        send_item(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        shadow_limit = value;
        limit_writes++;
    endtask

    task automatic test_reset_limit();
        pop_entry();
        push_entry(SEV_INFO, 16'h0000);
        push_entry(SEV_OVERFLOW, 16'hFFFF);
        push_entry(SEV_WARNING, 16'hA5A5);
        repeat (4) pop_entry();
    endtask

    task automatic test_eviction_order();
        write_limit(8'd3);
        push_entry(SEV_INFO, 16'h0001);
        push_entry(SEV_CRITICAL, 16'h0002);
        push_entry(SEV_WARNING, 16'h0003);
        push_entry(SEV_WARNING, 16'h0004);
        push_entry(SEV_INFO, 16'h0005);
        push_entry(SEV_CRITICAL, 16'h0006);
        push_entry(SEV_CRITICAL, 16'h0007);
        push_entry(SEV_CRITICAL, 16'h5A5A);
        repeat (4) pop_entry();
    endtask

    task automatic test_limit_floor();
        write_limit(8'd0);
        push_entry(SEV_WARNING, 16'h1234);
        push_entry(SEV_INFO, 16'hEDCB);
        push_entry(SEV_OVERFLOW, 16'h8001);
        pop_entry();
    endtask

    task automatic test_random_phase(input logic [7:0] lim, input int count,
                                     input int push_pct, input bit idle);
        in_item_t it;
        write_limit(lim);
        sender_idle   = idle;
        receiver_idle = idle;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 149) == 0) wait_drained();
            it.operation = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            it.severity  = 2'($urandom_range(0, 3));
            it.payload   = 16'($urandom_range(0, 65535));
            send_item(it);
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        shadow_count  = 0;
        shadow_drops  = '0;
        shadow_evicts = '0;
        shadow_limit  = FILL_LIMIT_RESET;
        error_count   = 0;
        results_seen  = 0;
        items_sent    = 0;
        limit_writes  = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_limit();
        test_eviction_order();
        test_limit_floor();
        test_random_phase(8'd1,   150, 60, 1'b1);
        test_random_phase(8'd2,   200, 65, 1'b0);
        test_random_phase(8'd5,   250, 55, 1'b1);
        test_random_phase(8'd128, 250, 85, 1'b1);
        test_random_phase(8'd255, 200, 50, 1'b0);
        test_random_phase(8'd3,   250, 50, 1'b1);
        test_random_phase(8'd0,   150, 55, 1'b1);
        test_random_phase(8'd16,  300, 60, 1'b1);
        test_random_phase(8'd7,   250, 45, 1'b1);

        s_valid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 50000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (200) @(posedge aclk);
        if (pending_results.size() != 0) begin
            error_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Sent %0d transactions and checked %0d results across %0d fill limits",
                 items_sent, results_seen, limit_writes);
        $display("Limits ranged 0 to 255 incl. lowering below the fill; %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
